[design/sjpe_pkg.sv]
// Shared types, codes and helpers for the symmetric Jacobi polynomial evaluator.
package sjpe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DEGREE_DEF = 63;
    localparam int MAX_ORDER_DEF  = 15;

    // Internal widths
    localparam int K_W    = 5;    // working order, up to order + 1
    localparam int N_W    = 7;    // working degree, up to degree + 1
    localparam int X_W    = 32;
    localparam int V_W    = 64;
    localparam int M_W    = 128;
    localparam int MULT_W = 16;

    // Operation codes
    localparam logic [2:0] OP_VALUE   = 3'd0;
    localparam logic [2:0] OP_DERIV   = 3'd1;
    localparam logic [2:0] OP_WEIGHT  = 3'd2;
    localparam logic [2:0] OP_WDERIV  = 3'd3;
    localparam logic [2:0] OP_WDERIV2 = 3'd4;

    // Final stage after the recurrence
    localparam logic [1:0] FIN_NONE   = 2'd0;
    localparam logic [1:0] FIN_SCALE  = 2'd1;
    localparam logic [1:0] FIN_WEIGHT = 2'd2;
    localparam logic [1:0] FIN_ZERO   = 2'd3;

    // Multiplier operand selects
    localparam logic [2:0] MS_C1X = 3'd0;
    localparam logic [2:0] MS_MA  = 3'd1;
    localparam logic [2:0] MS_MB  = 3'd2;
    localparam logic [2:0] MS_XX  = 3'd3;
    localparam logic [2:0] MS_FIN = 3'd4;

    // One decoded word of work
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [K_W-1:0]        k;
        logic [N_W-1:0]        n;
        logic [1:0]            fin;
        logic                  negate;
        logic                  halve;
        logic [MULT_W-1:0]     mult;
        logic                  ns;
    } job_t;

    // Controller to datapath
    typedef struct packed {
        logic       init;
        logic       mul_start;
        logic [2:0] msel;
        logic       keep_t;
        logic       keep_ma;
        logic       combine;
        logic       div_start;
        logic       fin_rnd;
        logic       step;
        logic       load_w;
        logic       fin_res;
        logic       out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic more;
        logic out_free;
    } stat_t;

    // Magnitude of a signed 64-bit value as unsigned
    function automatic logic [V_W-1:0] mag64(input logic [V_W-1:0] v);
        return v[V_W-1] ? (~v + 64'd1) : v;
    endfunction

endpackage

[design/sjpe_mul.sv]
// 64x64 unsigned multiplier: one 32x32 multiplier, partial products in turn.
module sjpe_mul
    import sjpe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [V_W-1:0] a,
    input  logic [V_W-1:0] b,
    output logic [M_W-1:0] prod,
    output logic           done
);

    logic [V_W-1:0] a_reg, a_next;
    logic [V_W-1:0] b_reg, b_next;
    logic [M_W-1:0] acc_reg, acc_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [31:0]    ah, bh;
    logic [63:0]    pp;
    logic [M_W-1:0] pp_sh;

    // Partial product for the current pair of halves
    always_comb
    begin
        ah = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bh = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'b0, ah} * {32'b0, bh};
        case (cnt_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end

    // Sequencing
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

[design/sjpe_div.sv]
// Restoring divider, one quotient bit per cycle, with rounding, sign and clamp.
module sjpe_div
    import sjpe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [M_W-1:0] dividend,
    input  logic [V_W-1:0] divisor,
    input  logic           neg,
    output logic [V_W-1:0] quot,
    output logic           sat,
    output logic           done
);

    logic [M_W-1:0] dvd_reg, dvd_next;
    logic [M_W-1:0] q_reg, q_next;
    logic [V_W-1:0] rem_reg, rem_next;
    logic [V_W-1:0] dsr_reg, dsr_next;
    logic           neg_reg, neg_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [V_W:0]   r2;
    logic [V_W:0]   r2_sub;
    logic           ge;
    logic [V_W-1:0] lim;
    logic [V_W-1:0] qmag;
    logic           over;

    // One restoring step
    always_comb
    begin
        r2     = {rem_reg, dvd_reg[M_W-1]};
        r2_sub = r2 - {1'b0, dsr_reg};
        ge     = (r2 >= {1'b0, dsr_reg});
    end

    // Sequencing; rounding offset is added to the dividend on start
    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend + {65'b0, divisor[V_W-1:1]};
            q_next    = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = neg;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? r2_sub[V_W-1:0] : r2[V_W-1:0];
            dvd_next = {dvd_reg[M_W-2:0], 1'b0};
            q_next   = {q_reg[M_W-2:0], ge};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Clamp to the signed range and apply the sign
    always_comb
    begin
        lim  = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        over = (|q_reg[M_W-1:V_W]) || (q_reg[V_W-1:0] > lim);
        qmag = over ? lim : q_reg[V_W-1:0];
        quot = neg_reg ? (~qmag + 64'd1) : qmag;
        sat  = over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;

endmodule

[design/sjpe_datapath.sv]
// Datapath: recurrence registers, shared multiplier, divider and output word.
module sjpe_datapath
    import sjpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  job_t                  job_in,
    output stat_t                 stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [V_W-1:0] result_value,
    output logic                  saturated,
    output logic                  not_supported
);

    job_t           job_reg;
    logic [N_W-1:0] i_reg;
    logic [V_W-1:0] p0_reg, p1_reg, t_reg, w_reg;
    logic [M_W-1:0] ma_reg, m_reg;
    logic           neg_reg, sat_reg;
    logic [M_W-1:0] rnd_reg;
    logic [V_W-1:0] res_out_reg;
    logic           sat_out_reg, ns_out_reg, out_valid_reg;

    logic [V_W-1:0] x_ext, x_mag, p0_mag, p1_mag, w_mag;
    logic [7:0]     ik, i2k;
    logic [8:0]     ik2m1;
    logic [16:0]    c1;
    logic [15:0]    c2, dd;
    logic [V_W-1:0] mul_a, mul_b;
    logic [M_W-1:0] prod;
    logic           mul_done;
    logic [M_W-1:0] div_dvd;
    logic [V_W-1:0] div_dsr;
    logic           div_neg;
    logic [V_W-1:0] quot;
    logic           div_sat, div_done;
    logic [M_W-1:0] sum;
    logic [M_W:0]   diff;
    logic           na, nb;
    logic [5:0]     kp1;
    logic signed [38:0] kx;
    logic [M_W-1:0] fin_half, fin_sum, fin_q;
    logic           fin_neg, fin_over;
    logic [V_W-1:0] fin_lim, fin_mag, fin_val;

    // Magnitudes and recurrence coefficients
    always_comb
    begin
        x_ext  = {{32{job_reg.x[X_W-1]}}, job_reg.x};
        x_mag  = mag64(x_ext);
        p0_mag = mag64(p0_reg);
        p1_mag = mag64(p1_reg);
        w_mag  = mag64(w_reg);
        ik     = 8'(i_reg) + 8'(job_reg.k);
        ik2m1  = {ik, 1'b0} - 9'd1;
        c1     = 17'(ik) * 17'(ik2m1);
        c2     = 16'(ik) * 16'(ik - 8'd1);
        i2k    = 8'(i_reg) + 8'({job_reg.k, 1'b0});
        dd     = 16'(i2k) * 16'(i_reg);
    end

    // Multiplier operands
    always_comb
    begin
        case (cmd.msel)
            MS_C1X:
            begin
                mul_a = 64'(c1);
                mul_b = x_mag;
            end
            MS_MA:
            begin
                mul_a = t_reg;
                mul_b = p1_mag;
            end
            MS_MB:
            begin
                mul_a = 64'({c2, 30'b0});
                mul_b = p0_mag;
            end
            MS_XX:
            begin
                mul_a = x_mag;
                mul_b = x_mag;
            end
            MS_FIN:
            begin
                mul_a = p1_mag;
                mul_b = (job_reg.fin == FIN_WEIGHT) ? w_mag : 64'(job_reg.mult);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands: one recurrence step
    always_comb
    begin
        div_dvd = m_reg;
        div_dsr = 64'({dd, 30'b0});
        div_neg = neg_reg;
    end

    // Final scaling divides by 1, 2 or 2^60: round half up, then shift
    always_comb
    begin
        if (job_reg.fin == FIN_WEIGHT)
            fin_half = 128'd1 << 59;
        else if (job_reg.halve)
            fin_half = 128'd1;
        else
            fin_half = 128'd0;
        fin_sum = prod + fin_half;
        if (job_reg.fin == FIN_WEIGHT)
            fin_q = {60'b0, fin_sum[M_W-1:60]};
        else if (job_reg.halve)
            fin_q = {1'b0, fin_sum[M_W-1:1]};
        else
            fin_q = fin_sum;
    end

    // Clamp the final quotient and apply the sign
    always_comb
    begin
        fin_neg  = (job_reg.fin == FIN_WEIGHT) ? (p1_reg[V_W-1] ^ w_reg[V_W-1])
                                               : (p1_reg[V_W-1] ^ job_reg.negate);
        fin_lim  = fin_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        fin_over = (|rnd_reg[M_W-1:V_W]) || (rnd_reg[V_W-1:0] > fin_lim);
        fin_mag  = fin_over ? fin_lim : rnd_reg[V_W-1:0];
        fin_val  = fin_neg ? (~fin_mag + 64'd1) : fin_mag;
    end

    // Signed numerator from the two products
    always_comb
    begin
        na   = job_reg.x[X_W-1] ^ p1_reg[V_W-1];
        nb   = ~p0_reg[V_W-1];
        sum  = ma_reg + prod;
        diff = {1'b0, ma_reg} - {1'b0, prod};
    end

    // First-order term at start
    always_comb
    begin
        kp1 = 6'(job_in.k) + 6'd1;
        kx  = $signed({1'b0, kp1}) * job_in.x;
    end

    sjpe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    sjpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .neg      (div_neg),
        .quot     (quot),
        .sat      (div_sat),
        .done     (div_done)
    );

    // Recurrence registers
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            job_reg <= job_in;
            i_reg   <= 7'd2;
            p0_reg  <= 64'h0000_0000_4000_0000;
            p1_reg  <= (job_in.n == '0) ? 64'h0000_0000_4000_0000
                                        : {{25{kx[38]}}, kx};
            sat_reg <= 1'b0;
        end
        if (cmd.keep_t)
            t_reg <= prod[V_W-1:0];
        if (cmd.keep_ma)
            ma_reg <= prod;
        if (cmd.combine)
        begin
            if (na == nb)
            begin
                m_reg   <= sum;
                neg_reg <= na;
            end
            else if (!diff[M_W])
            begin
                m_reg   <= diff[M_W-1:0];
                neg_reg <= na;
            end
            else
            begin
                m_reg   <= ~diff[M_W-1:0] + 128'd1;
                neg_reg <= nb;
            end
        end
        if (cmd.step)
        begin
            p0_reg  <= p1_reg;
            p1_reg  <= quot;
            i_reg   <= i_reg + 7'd1;
            sat_reg <= sat_reg | div_sat;
        end
        if (cmd.fin_rnd)
            rnd_reg <= fin_q;
        if (cmd.fin_res)
        begin
            p1_reg  <= fin_val;
            sat_reg <= sat_reg | fin_over;
        end
        if (cmd.load_w)
            w_reg <= 64'h1000_0000_0000_0000 - prod[V_W-1:0];
        if (cmd.out_load)
        begin
            res_out_reg <= (job_reg.fin == FIN_ZERO) ? '0 : p1_reg;
            sat_out_reg <= sat_reg;
            ns_out_reg  <= job_reg.ns;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.more     = (i_reg <= job_reg.n);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign result_value  = res_out_reg;
    assign saturated     = sat_out_reg;
    assign not_supported = ns_out_reg;

endmodule

[design/sjpe_ctrl.sv]
// Controller: decodes the operation and sequences the recurrence steps.
module sjpe_ctrl
    import sjpe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            operation,
    input  logic [5:0]            degree,
    input  logic signed [X_W-1:0] x_value,
    input  logic [3:0]            order_k,
    input  stat_t                 stat,
    output cmd_t                  cmd,
    output job_t                  job
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_C1S   = 5'd2;
    localparam logic [4:0] S_C1W   = 5'd3;
    localparam logic [4:0] S_MAS   = 5'd4;
    localparam logic [4:0] S_MAW   = 5'd5;
    localparam logic [4:0] S_MBS   = 5'd6;
    localparam logic [4:0] S_MBW   = 5'd7;
    localparam logic [4:0] S_COMB  = 5'd8;
    localparam logic [4:0] S_DVS   = 5'd9;
    localparam logic [4:0] S_DVW   = 5'd10;
    localparam logic [4:0] S_FXS   = 5'd11;
    localparam logic [4:0] S_FXW   = 5'd12;
    localparam logic [4:0] S_FPS   = 5'd13;
    localparam logic [4:0] S_FPW   = 5'd14;
    localparam logic [4:0] S_FDS   = 5'd15;
    localparam logic [4:0] S_FDW   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] fin_reg, fin_next;
    logic       accept;
    logic [5:0] deg_c;
    logic [N_W-1:0] n_c;
    logic [K_W-1:0] k_c;
    job_t       deriv;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // Operation decode
    always_comb
    begin
        deg_c = (32'(degree) > MAX_DEGREE) ? 6'(MAX_DEGREE) : degree;
        n_c   = 7'(deg_c);
        k_c   = 5'(order_k);

        deriv        = '0;
        deriv.x      = x_value;
        deriv.k      = k_c + 5'd1;
        deriv.n      = n_c - 7'd1;
        deriv.fin    = (n_c == '0) ? FIN_ZERO : FIN_SCALE;
        deriv.halve  = 1'b1;
        deriv.mult   = 16'(n_c) + 16'({k_c, 1'b0}) + 16'd1;

        job   = '0;
        job.x = x_value;
        job.k = k_c;
        job.n = n_c;
        unique case (operation)
            OP_VALUE:
                job.fin = FIN_NONE;
            OP_DERIV:
                job = deriv;
            OP_WEIGHT:
                job.fin = FIN_WEIGHT;
            OP_WDERIV:
            begin
                if (k_c == '0)
                    job = deriv;
                else
                begin
                    job.k      = k_c - 5'd1;
                    job.n      = n_c + 7'd1;
                    job.fin    = FIN_SCALE;
                    job.negate = 1'b1;
                    job.mult   = 16'({n_c + 7'd1, 1'b0});
                end
            end
            OP_WDERIV2:
            begin
                if (k_c == '0)
                begin
                    job.fin = FIN_ZERO;
                    job.ns  = 1'b1;
                end
                else
                begin
                    job.fin    = FIN_SCALE;
                    job.negate = 1'b1;
                    job.mult   = (16'(n_c) + 16'd1) * (16'(n_c) + 16'({k_c, 1'b0}));
                end
            end
            default:
                job.fin = FIN_ZERO;
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.init   = 1'b1;
                    fin_next   = job.fin;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fin_reg == FIN_ZERO)
                    state_next = S_DONE;
                else if (stat.more)
                    state_next = S_C1S;
                else if (fin_reg == FIN_SCALE)
                    state_next = S_FPS;
                else if (fin_reg == FIN_WEIGHT)
                    state_next = S_FXS;
                else
                    state_next = S_DONE;
            end
            S_C1S:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = MS_C1X;
                state_next    = S_C1W;
            end
            S_C1W:
            begin
                if (stat.mul_done)
                begin
                    cmd.keep_t = 1'b1;
                    state_next = S_MAS;
                end
            end
            S_MAS:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = MS_MA;
                state_next    = S_MAW;
            end
            S_MAW:
            begin
                if (stat.mul_done)
                begin
                    cmd.keep_ma = 1'b1;
                    state_next  = S_MBS;
                end
            end
            S_MBS:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = MS_MB;
                state_next    = S_MBW;
            end
            S_MBW:
            begin
                if (stat.mul_done)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = S_DVS;
            end
            S_DVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DVW;
            end
            S_DVW:
            begin
                if (stat.div_done)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_FXS:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = MS_XX;
                state_next    = S_FXW;
            end
            S_FXW:
            begin
                if (stat.mul_done)
                begin
                    cmd.load_w = 1'b1;
                    state_next = S_FPS;
                end
            end
            S_FPS:
            begin
                cmd.mul_start = 1'b1;
                cmd.msel      = MS_FIN;
                state_next    = S_FPW;
            end
            S_FPW:
            begin
                if (stat.mul_done)
                    state_next = S_FDS;
            end
            // final rounding shift, then clamp
            S_FDS:
            begin
                cmd.fin_rnd = 1'b1;
                state_next  = S_FDW;
            end
            S_FDW:
            begin
                cmd.fin_res = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= FIN_NONE;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

[design/symmetric_jacobi_poly_eval.sv]
// Top level of the symmetric Jacobi polynomial evaluator.
//
// Input channel (in_valid / in_stall) takes one word: operation, degree and
// x_value (Q2.30). Output channel (out_valid / out_stall) returns one word per
// input: result_value (Q34.30, saturating), saturated and not_supported. The
// user writes order_k over the APB port at byte address 0 only while the block
// idles; the block itself does not enforce this.
// One word is worked on at a time; in_stall is high from acceptance until the
// result has moved into the output register. Each recurrence step runs three
// multiplies on the shared 32x32 multiplier and then the bit-serial divider,
// which sets the rate, with sequencing states between. The final scaling is a
// multiply, then a rounding shift and a clamp; weighted words first form the
// weight from x squared. Undefined words skip the recurrence and the scaling.
// The output register lets the next word start while a result waits; if the
// receiver keeps stalling, the next result waits in the controller.
// Reset clears order_k to 0, empties the output register and idles the block.
module symmetric_jacobi_poly_eval
    import sjpe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            operation,
    input  logic [5:0]            degree,
    input  logic signed [X_W-1:0] x_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [V_W-1:0] result_value,
    output logic                  saturated,
    output logic                  not_supported,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [3:0] order_reg;
    logic [3:0] order_next;
    cmd_t       cmd;
    stat_t      stat;
    job_t       job;

    // Configuration register, clamped on write
    assign pready     = 1'b1;
    assign order_next = (32'(pwdata[3:0]) > MAX_ORDER) ? 4'(MAX_ORDER) : pwdata[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 4'd0;
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
            order_reg <= order_next;
    end

    assign prdata = (paddr[2] == 1'b0) ? {28'b0, order_reg} : 32'b0;

    sjpe_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .degree    (degree),
        .x_value   (x_value),
        .order_k   (order_reg),
        .stat      (stat),
        .cmd       (cmd),
        .job       (job)
    );

    sjpe_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .job_in        (job),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .saturated     (saturated),
        .not_supported (not_supported)
    );

endmodule

[design/sjpe_checker.sv]
// Port-level checks for the evaluator, bound to the top level.
module sjpe_checker
    import sjpe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic signed [V_W-1:0] result_value,
    input logic                  saturated,
    input logic                  not_supported
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("output word changed under stall");

    // Unsupported words carry a zero value and no clip
    a_ns_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_supported |-> result_value == 64'sd0 && !saturated)
        else $error("unsupported word has nonzero value or clip");

    // The block is busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after acceptance");

endmodule

bind symmetric_jacobi_poly_eval sjpe_checker u_sjpe_checker (.*);

[bench/symmetric_jacobi_poly_eval_tb.sv]
// Self-checking testbench for the symmetric Jacobi polynomial evaluator.
`timescale 1ns / 100ps

module symmetric_jacobi_poly_eval_tb;
    import sjpe_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_MID = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam logic [2:0] ADDR_ORDER_K = 3'd0;
    localparam int MAX_DEG = 63;
    localparam int IDLE_PCT = 16;
    localparam int HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 <<< 30;

    typedef struct packed {
        logic signed [63:0] value;
        logic               sat;
        logic               ns;
    } poly_result_t;

    typedef struct {
        logic [2:0]         op;
        logic [5:0]         deg;
        logic signed [31:0] x;
        bit                 typed;
        poly_result_t       res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] operation = '0;
    logic [5:0] degree = '0;
    logic signed [31:0] x_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] result_value;
    logic saturated;
    logic not_supported;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    symmetric_jacobi_poly_eval uut (.*);

    always #10 clk = ~clk;

    // Model state and bookkeeping
    int unsigned cur_order = 0;
    bit          step_sat;
    poly_result_t pending_results[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int sat_seen = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] abs_u64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // round(sign * m / d) half away from zero, clamped to signed 64 bits
    function automatic logic signed [63:0] round_clamp(input bit neg, input logic [127:0] m,
                                                       input logic [63:0] d);
        logic [127:0] q;
        logic [127:0] lim;
        q = (m + {64'd0, d >> 1}) / {64'd0, d};
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
        if (q > lim)
        begin
            step_sat = 1'b1;
            q = lim;
        end
        return neg ? -q[63:0] : q[63:0];
    endfunction

    function automatic logic signed [63:0] scale_by(input logic signed [63:0] v, input bit negate,
                                                    input logic [63:0] mult, input logic [63:0] div);
        return round_clamp((v < 0) != negate, {64'd0, abs_u64(v)} * {64'd0, mult}, div);
    endfunction

    function automatic logic signed [63:0] jacobi_rec(input int k, input int n,
                                                      input logic signed [63:0] x);
        logic signed [63:0] p0, p1;
        logic [63:0] c1, c2, d;
        logic [127:0] ma, mb, m;
        bit na, nb, neg;
        p0 = ONE_Q30;
        p1 = x * (k + 1);
        if (n == 0)
            return p0;
        for (int i = 2; i <= n; i++)
        begin
            c1 = (i + k) * (2 * i + 2 * k - 1);
            c2 = (i + k) * (i + k - 1);
            d = (i + 2 * k) * i;
            na = (x < 0) != (p1 < 0);
            ma = {64'd0, c1 * abs_u64(x)} * {64'd0, abs_u64(p1)};
            nb = !(p0 < 0);
            mb = {64'd0, c2 << 30} * {64'd0, abs_u64(p0)};
            if (na == nb)
            begin
                neg = na;
                m = ma + mb;
            end
            else if (ma >= mb)
            begin
                neg = na;
                m = ma - mb;
            end
            else
            begin
                neg = nb;
                m = mb - ma;
            end
            p0 = p1;
            p1 = round_clamp(neg, m, d << 30);
        end
        return p1;
    endfunction

    function automatic logic signed [63:0] deriv_of(input int k, input int n,
                                                    input logic signed [63:0] x);
        if (n == 0)
            return 0;
        return scale_by(jacobi_rec(k + 1, n - 1, x), 1'b0, n + 2 * k + 1, 2);
    endfunction

    function automatic poly_result_t predict_poly(input logic [2:0] op, input logic [5:0] deg,
                                                  input logic signed [31:0] xin);
        poly_result_t r;
        logic signed [63:0] x, w, p;
        int k, n;
        k = cur_order;
        n = (deg > MAX_DEG) ? MAX_DEG : deg;
        x = xin;
        step_sat = 1'b0;
        r = '0;
        case (op)
            OP_VALUE: r.value = jacobi_rec(k, n, x);
            OP_DERIV: r.value = deriv_of(k, n, x);
            OP_WEIGHT:
            begin
                w = (64'sd1 <<< 60) - x * x;
                p = jacobi_rec(k, n, x);
                r.value = round_clamp((p < 0) != (w < 0),
                                      {64'd0, abs_u64(p)} * {64'd0, abs_u64(w)}, 64'd1 << 60);
            end
            OP_WDERIV:
                if (k == 0)
                    r.value = deriv_of(0, n, x);
                else
                    r.value = scale_by(jacobi_rec(k - 1, n + 1, x), 1'b1, 2 * (n + 1), 1);
            OP_WDERIV2:
                if (k == 0)
                    r.ns = 1'b1;
                else
                    r.value = scale_by(jacobi_rec(k, n, x), 1'b1, (n + 1) * (n + 2 * k), 1);
            default: ;
        endcase
        r.sat = step_sat;
        return r;
    endfunction

    // ---------------- mismatch reporting ----------------
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: word %0d %s mismatch: got %h expected %h", $time, words_out, field,
                 got, want);
        errors++;
    endtask

    // ---------------- input side ----------------
    task automatic send_word(input logic [2:0] op, input logic [5:0] deg,
                             input logic signed [31:0] x, input bit typed,
                             input poly_result_t typed_res);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        degree <= deg;
        x_value <= x;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.insert(pending_results.size(),
                               typed ? typed_res : predict_poly(op, deg, x));
        words_in++;
    endtask

    task automatic send_random;
        logic [2:0] op;
        logic [5:0] deg;
        logic signed [31:0] x;
        int pick;
        op = ($urandom_range(99) < 8) ? 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO))
                                      : 3'($urandom_range(OP_WDERIV2, OP_VALUE));
        pick = $urandom_range(99);
        // mostly short recurrences; the long ones are slow
        if (pick < 80)
            deg = 6'($urandom_range(8));
        else if (pick < 94)
            deg = 6'($urandom_range(24, 9));
        else
            deg = 6'($urandom_range(MAX_DEG, 32));
        pick = $urandom_range(99);
        if (pick < 40)
            x = $urandom;
        else if (pick < 80)
            x = $signed(32'($urandom_range(32'h4000_0000))) * ($urandom_range(1) ? 1 : -1);
        else
            x = $signed(32'($urandom_range(4096))) - 2048;
        send_word(op, deg, x, 1'b0, '0);
    endtask

    task automatic idle_input;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // APB write: setup then access phase
    task automatic write_order(input int k);
        @(negedge clk);
        in_valid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ORDER_K;
        pwdata <= {28'($urandom), 4'(k)};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_order = k;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // ---------------- output side ----------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        poly_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, result_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (saturated)
                    sat_seen++;
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
                if (not_supported !== want.ns)
                    report_mismatch("not_supported", not_supported, want.ns);
            end
        end
    end

    // watchdog on progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("symmetric_jacobi_poly_eval_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- main sequence ----------------
    stim_row_t directed[16];
    int phase_orders[6] = '{15, 1, 0, 7, 3, 15};

    initial
    begin
        // typed: degree 0, degree 1 at x limits, undefined ops, order-zero 2nd derivative
        directed = '{
            '{OP_VALUE, 6'd0, 32'sd0, 1'b1, '{ONE_Q30, 1'b0, 1'b0}},
            '{OP_VALUE, 6'd0, 32'h8000_0000, 1'b1, '{ONE_Q30, 1'b0, 1'b0}},
            '{OP_DERIV, 6'd0, 32'h4000_0000, 1'b1, '{64'sd0, 1'b0, 1'b0}},
            '{OP_WDERIV2, 6'd5, 32'sd123, 1'b1, '{64'sd0, 1'b0, 1'b1}},
            '{OP_UNDEF_LO, 6'd63, 32'h7fff_ffff, 1'b1, '{64'sd0, 1'b0, 1'b0}},
            '{OP_UNDEF_MID, 6'd1, 32'h4000_0000, 1'b1, '{64'sd0, 1'b0, 1'b0}},
            '{OP_UNDEF_HI, 6'd0, 32'h8000_0000, 1'b1, '{64'sd0, 1'b0, 1'b0}},
            '{OP_VALUE, 6'd1, 32'h7fff_ffff, 1'b1, '{64'sd2147483647, 1'b0, 1'b0}},
            '{OP_VALUE, 6'd1, 32'h8000_0000, 1'b1, '{-64'sd2147483648, 1'b0, 1'b0}},
            '{OP_VALUE, 6'd63, 32'h4000_0000, 1'b0, '0},
            '{OP_VALUE, 6'd63, 32'hc000_0000, 1'b0, '0},
            '{OP_VALUE, 6'd63, 32'h7fff_ffff, 1'b0, '0},
            '{OP_WEIGHT, 6'd10, 32'h2000_0000, 1'b0, '0},
            '{OP_WDERIV, 6'd7, 32'h1555_5555, 1'b0, '0},
            '{OP_DERIV, 6'd63, 32'hecc_cccd, 1'b0, '0},
            '{OP_WEIGHT, 6'd0, 32'h8000_0000, 1'b0, '0}
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].op, directed[i].deg, directed[i].x, directed[i].typed,
                      directed[i].res);
        idle_input();
        drain();

        foreach (phase_orders[p])
        begin
            write_order(phase_orders[p]);
            // no idling on either side for one whole phase
            no_idle = (p == 1);
            if (p == 0)
                hold_req = 1'b1;
            for (int j = 0; j < 21; j++)
                send_random();
            idle_input();
            // sender waits for all results before the next register write
            drain();
            no_idle = 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d words over order settings 0, 1, 3, 7 and 15, %0d saturated;",
                 words_in, sat_seen);
        $display("long receiver hold-off, no-idle phase and drained pauses included.");
        if (errors == 0)
            $display("symmetric_jacobi_poly_eval_tb passed");
        else
            $display("symmetric_jacobi_poly_eval_tb failed");
        $finish;
    end

endmodule

[sim.f]
design/sjpe_pkg.sv
design/sjpe_mul.sv
design/sjpe_div.sv
design/sjpe_datapath.sv
design/sjpe_ctrl.sv
design/symmetric_jacobi_poly_eval.sv
design/sjpe_checker.sv
bench/symmetric_jacobi_poly_eval_tb.sv
